// File: rtl/bspwm_pkg.sv
// shared types, constants and duty helpers for the button stepped pwm block
package bspwm_pkg;

    localparam int CFG_W       = 16;
    localparam int DUTY_W      = 7;
    localparam int CFG_INDEX_W = 1;
    localparam int PROD_W      = CFG_W + DUTY_W;

    localparam int DEFAULT_COUNT_WIDTH = 16;
    localparam int DEFAULT_DUTY_STEP   = 10;

    localparam logic [CFG_W-1:0]  RESET_PERIOD_TOP = 16'd62499;
    localparam logic [CFG_W-1:0]  RESET_DEBOUNCE   = 16'd1250;
    localparam logic [CFG_W-1:0]  RESET_COMPARE    = 16'd6249;
    localparam logic [DUTY_W-1:0] DUTY_MIN         = 7'd10;
    localparam logic [DUTY_W-1:0] DUTY_MAX         = 7'd100;
    localparam logic [DUTY_W-1:0] RESET_DUTY       = DUTY_MIN;

    // divide by one hundred with one reciprocal multiply, exact for any PROD_W bit dividend
    localparam int RECIP_W   = 24;
    localparam int MUL_W     = PROD_W + RECIP_W;
    localparam int DIV_SHIFT = 30;
    localparam logic [RECIP_W-1:0] DIV_RECIP = 24'd10737419;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PERIOD_TOP     = 1'b0,
        CFG_DEBOUNCE_TICKS = 1'b1
    } t_cfg_reg;

    function automatic logic [DUTY_W-1:0] duty_up(input logic [DUTY_W-1:0] d,
                                                  input logic [DUTY_W:0] step);
        logic [DUTY_W:0] s;
        s = {1'b0, d} + step;
        if (s > {1'b0, DUTY_MAX}) begin
            s = {1'b0, DUTY_MAX};
        end
        return s[DUTY_W-1:0];
    endfunction

    function automatic logic [DUTY_W-1:0] duty_down(input logic [DUTY_W-1:0] d,
                                                    input logic [DUTY_W:0] step);
        logic [DUTY_W:0] s;
        s = {1'b0, d} - step;
        if ({1'b0, d} >= ({1'b0, DUTY_MIN} + step)) begin
            return s[DUTY_W-1:0];
        end
        return DUTY_MIN;
    endfunction

endpackage

// File: rtl/bspwm_if.sv
// channel interfaces: button ticks in, pwm results out, register writes
interface bspwm_in_if;
    logic valid;
    logic ready;
    logic up_level;
    logic down_level;
    modport source(output valid, output up_level, output down_level, input ready);
    modport sink(input valid, input up_level, input down_level, output ready);
endinterface

interface bspwm_out_if;
    logic                           valid;
    logic                           ready;
    logic                           pwm_level;
    logic [bspwm_pkg::DUTY_W-1:0]   duty_percent;
    logic                           period_wrap;
    modport source(output valid, output pwm_level, output duty_percent,
                   output period_wrap, input ready);
    modport sink(input valid, input pwm_level, input duty_percent,
                 input period_wrap, output ready);
endinterface

interface bspwm_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [bspwm_pkg::CFG_INDEX_W-1:0]  index;
    logic [bspwm_pkg::CFG_W-1:0]        data;
    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

// File: rtl/bspwm_debounce.sv
// falling edge detect and recheck wait for one active low button
module bspwm_debounce (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_advance,
    input  logic                        i_level,
    input  logic [bspwm_pkg::CFG_W-1:0] i_debounce_ticks,
    output logic                        o_fire
);

    logic [bspwm_pkg::CFG_W-1:0] r_wait;
    logic [bspwm_pkg::CFG_W-1:0] n_wait;
    logic                        r_prev;

    always_comb begin
        n_wait = r_wait;
        o_fire = 1'b0;
        if (r_wait != '0) begin
            n_wait = r_wait - 1'b1;
            o_fire = (n_wait == '0) && !i_level;
        end else if (r_prev && !i_level) begin
            if (i_debounce_ticks == '0) begin
                o_fire = 1'b1;
            end else begin
                n_wait = i_debounce_ticks;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait <= '0;
            r_prev <= 1'b1;
        end else if (i_advance) begin
            r_wait <= n_wait;
            r_prev <= i_level;
        end
    end

endmodule

// File: rtl/bspwm_div100.sv
// divide the compare product by one hundred with a reciprocal multiply
module bspwm_div100 (
    input  logic [bspwm_pkg::PROD_W-1:0] i_dividend,
    output logic [bspwm_pkg::CFG_W-1:0]  o_quotient
);

    logic [bspwm_pkg::MUL_W-1:0] w_mul;

    assign w_mul      = bspwm_pkg::MUL_W'(i_dividend) * bspwm_pkg::MUL_W'(bspwm_pkg::DIV_RECIP);
    assign o_quotient = w_mul[bspwm_pkg::DIV_SHIFT +: bspwm_pkg::CFG_W];

endmodule

// File: rtl/button_stepped_pwm.sv
// top level: fast pwm counter with double buffered compare and duty step buttons
//
//  channel   | direction | payload                                  | transfer
//  ----------+-----------+------------------------------------------+---------------
//  i_item    | in        | up_level, down_level                     | valid & ready
//  o_result  | out       | pwm_level, duty_percent, period_wrap     | valid & ready
//  i_cfg     | in        | index, data (period_top, debounce_ticks) | valid & ready
//
//  one item per cycle sustained unless the result stalls; each item goes through the
//  input register, then the result register; the counter, buttons and duty update
//  in the cycle an item moves from the input register to the result register
//  a stalled result holds the input register, new items are taken while it drains
//  reset is synchronous; counters and button waits clear, duty and compare reload
module button_stepped_pwm #(
    parameter int COUNT_WIDTH = bspwm_pkg::DEFAULT_COUNT_WIDTH,
    parameter int DUTY_STEP   = bspwm_pkg::DEFAULT_DUTY_STEP
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bspwm_cfg_if.sink             i_cfg,
    bspwm_in_if.sink              i_item,
    bspwm_out_if.source           o_result
);

    localparam int CMP_W = (COUNT_WIDTH > bspwm_pkg::CFG_W) ? COUNT_WIDTH : bspwm_pkg::CFG_W;
    localparam logic [bspwm_pkg::DUTY_W:0] STEP = (bspwm_pkg::DUTY_W + 1)'(DUTY_STEP);

    logic [bspwm_pkg::CFG_W-1:0]  r_period_top;
    logic [bspwm_pkg::CFG_W-1:0]  r_debounce;

    logic                         r_in_valid;
    logic                         r_in_up;
    logic                         r_in_down;

    logic [COUNT_WIDTH-1:0]       r_count;
    logic [COUNT_WIDTH-1:0]       n_count;
    logic [CMP_W-1:0]             r_active;
    logic [CMP_W-1:0]             n_active;
    logic [bspwm_pkg::PROD_W-1:0] r_pend_prod;
    logic [bspwm_pkg::PROD_W-1:0] n_pend_prod;
    logic                         r_pend_init;
    logic [bspwm_pkg::DUTY_W-1:0] r_duty;
    logic [bspwm_pkg::DUTY_W-1:0] n_duty;

    logic                         r_out_valid;
    logic                         r_out_pwm;
    logic [bspwm_pkg::DUTY_W-1:0] r_out_duty;
    logic                         r_out_wrap;

    logic                         advance;
    logic                         wrap;
    logic                         pwm;
    logic [CMP_W-1:0]             count_ext;
    logic [CMP_W-1:0]             quot_ext;
    logic [CMP_W-1:0]             pend_cmp;
    logic [bspwm_pkg::CFG_W-1:0]  quotient;
    logic                         fire_up;
    logic                         fire_down;
    logic                         up_ok;
    logic                         down_ok;
    logic [bspwm_pkg::DUTY_W-1:0] duty_mid;

    // configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period_top <= bspwm_pkg::RESET_PERIOD_TOP;
            r_debounce   <= bspwm_pkg::RESET_DEBOUNCE;
        end else if (i_cfg.valid) begin
            unique case (bspwm_pkg::t_cfg_reg'(i_cfg.index))
                bspwm_pkg::CFG_PERIOD_TOP:     r_period_top <= i_cfg.data;
                bspwm_pkg::CFG_DEBOUNCE_TICKS: r_debounce   <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // handshake
    assign advance      = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.ready && i_item.valid) begin
            r_in_up   <= i_item.up_level;
            r_in_down <= i_item.down_level;
        end
    end

    // counter and compare
    assign count_ext = CMP_W'(r_count);
    assign wrap      = count_ext >= CMP_W'(r_period_top);
    assign pwm       = count_ext <= r_active;
    assign n_count   = wrap ? '0 : r_count + COUNT_WIDTH'(1);

    bspwm_div100 u_div (
        .i_dividend (r_pend_prod),
        .o_quotient (quotient)
    );

    assign quot_ext = CMP_W'(quotient);
    assign pend_cmp = r_pend_init ? CMP_W'(bspwm_pkg::RESET_COMPARE)
                                  : CMP_W'(quot_ext[COUNT_WIDTH-1:0]);
    assign n_active = wrap ? pend_cmp : r_active;

    // buttons
    bspwm_debounce u_deb_up (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_advance        (advance),
        .i_level          (r_in_up),
        .i_debounce_ticks (r_debounce),
        .o_fire           (fire_up)
    );

    bspwm_debounce u_deb_down (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_advance        (advance),
        .i_level          (r_in_down),
        .i_debounce_ticks (r_debounce),
        .o_fire           (fire_down)
    );

    // up handled before down
    assign up_ok    = fire_up && (r_duty < bspwm_pkg::DUTY_MAX);
    assign duty_mid = up_ok ? bspwm_pkg::duty_up(r_duty, STEP) : r_duty;
    assign down_ok  = fire_down && (duty_mid > bspwm_pkg::DUTY_MIN);
    assign n_duty   = down_ok ? bspwm_pkg::duty_down(duty_mid, STEP) : duty_mid;
    assign n_pend_prod = bspwm_pkg::PROD_W'(r_period_top) * bspwm_pkg::PROD_W'(n_duty);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_active    <= CMP_W'(bspwm_pkg::RESET_COMPARE);
            r_pend_prod <= '0;
            r_pend_init <= 1'b1;
            r_duty      <= bspwm_pkg::RESET_DUTY;
        end else if (advance) begin
            r_count  <= n_count;
            r_active <= n_active;
            r_duty   <= n_duty;
            if (up_ok || down_ok) begin
                r_pend_prod <= n_pend_prod;
                r_pend_init <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_pwm  <= pwm;
            r_out_duty <= n_duty;
            r_out_wrap <= wrap;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.pwm_level    = r_out_pwm;
    assign o_result.duty_percent = r_out_duty;
    assign o_result.period_wrap  = r_out_wrap;

endmodule

// File: rtl/bspwm_checker.sv
// port level checks for the button stepped pwm block, bound to the top level
module bspwm_checker #(
    parameter int DUTY_STEP = bspwm_pkg::DEFAULT_DUTY_STEP
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic                         i_out_pwm,
    input logic [bspwm_pkg::DUTY_W-1:0] i_out_duty,
    input logic                         i_out_wrap
);

    localparam logic [bspwm_pkg::DUTY_W:0] STEP = (bspwm_pkg::DUTY_W + 1)'(DUTY_STEP);

    logic out_xfer;
    assign out_xfer = i_out_valid && i_out_ready;

    // duty stays within its saturation limits
    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_duty >= bspwm_pkg::DUTY_MIN) &&
                        (i_out_duty <= bspwm_pkg::DUTY_MAX))
        else $error("duty outside limits");

    // one tick moves the duty by at most one step either way
    a_duty_slew: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && $past(out_xfer) && $past(i_rst_n) |->
            ({1'b0, i_out_duty} <= ({1'b0, $past(i_out_duty)} + STEP)) &&
            ({1'b0, $past(i_out_duty)} <= ({1'b0, i_out_duty} + STEP)))
        else $error("duty changed by more than one step");

    // no result straight out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_pwm) && $stable(i_out_duty) && $stable(i_out_wrap))
        else $error("stalled result changed");

endmodule

bind button_stepped_pwm bspwm_checker #(.DUTY_STEP(DUTY_STEP)) u_bspwm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_pwm   (o_result.pwm_level),
    .i_out_duty  (o_result.duty_percent),
    .i_out_wrap  (o_result.period_wrap)
);

// File: tb/button_stepped_pwm_tb.sv
// self-checking testbench for the button stepped pwm block, directed table then random sets
`timescale 1ns / 100ps

module button_stepped_pwm_tb;
    import bspwm_pkg::*;

    localparam int COUNT_W       = DEFAULT_COUNT_WIDTH;
    localparam int STEP          = DEFAULT_DUTY_STEP;
    localparam int BTN_UP        = 0;
    localparam int BTN_DN        = 1;
    localparam int TICKS_PER_SET = 48;
    localparam int DRAIN_CYCLES  = 4;
    localparam int STALL_CYCLES  = 100;
    localparam int TIMEOUT_NS    = 5_000_000;
    localparam int NUM_ROWS      = 31;

    typedef struct packed {
        logic              pwm;
        logic [DUTY_W-1:0] duty;
        logic              wrap;
    } t_pwm_result;

    typedef enum {ROW_TICK, ROW_WRITE} t_row_kind;

    typedef struct {
        t_row_kind        kind;
        bit               up;
        bit               dn;
        t_cfg_reg         idx;
        logic [CFG_W-1:0] data;
        bit               typed;
        t_pwm_result      want;
    } t_stim_row;

    localparam t_pwm_result UNTYPED = '0;

    // reset values, count above top, zero debounce, bounce during wait, release at recheck,
    // top extremes and a top change that leaves the pending compare alone
    t_stim_row directed_rows [NUM_ROWS] = '{
        '{ROW_TICK,  1'b1, 1'b1, CFG_PERIOD_TOP,     16'd0,     1'b1, '{1'b1, 7'd10, 1'b0}},
        '{ROW_TICK,  1'b1, 1'b1, CFG_PERIOD_TOP,     16'd0,     1'b1, '{1'b1, 7'd10, 1'b0}},
        '{ROW_WRITE, 1'b1, 1'b1, CFG_PERIOD_TOP,     16'd1,     1'b0, UNTYPED},
        '{ROW_WRITE, 1'b1, 1'b1, CFG_DEBOUNCE_TICKS, 16'd0,     1'b0, UNTYPED},
        '{ROW_TICK,  1'b1, 1'b1, CFG_PERIOD_TOP,     16'd0,     1'b1, '{1'b1, 7'd10, 1'b1}},
        '{ROW_TICK,  1'b0, 1'b1, CFG_PERIOD_TOP,     16'd0,     1'b1, '{1'b1, 7'd20, 1'b0}},
        '{ROW_TICK,  1'b1, 1'b0, CFG_PERIOD_TOP,     16'd0,     1'b1, '{1'b1, 7'd10, 1'b1}},
        '{ROW_TICK,  1'b0, 1'b0, CFG_PERIOD_TOP,     16'd0,     1'b0, UNTYPED},
        '{ROW_TICK,  1'b1, 1'b1, CFG_PERIOD_TOP,     16'd0,     1'b0, UNTYPED},
        '{ROW_WRITE, 1'b1, 1'b1, CFG_DEBOUNCE_TICKS, 16'd3,     1'b0, UNTYPED},
        '{ROW_TICK,  1'b0, 1'b1, CFG_PERIOD_TOP,     16'd0,     1'b0, UNTYPED},
        '{ROW_TICK,  1'b1, 1'b1, CFG_PERIOD_TOP,     16'd0,     1'b0, UNTYPED},
        '{ROW_TICK,  1'b0, 1'b1, CFG_PERIOD_TOP,     16'd0,     1'b0, UNTYPED},
        '{ROW_TICK,  1'b0, 1'b1, CFG_PERIOD_TOP,     16'd0,     1'b0, UNTYPED},
        '{ROW_TICK,  1'b1, 1'b1, CFG_PERIOD_TOP,     16'd0,     1'b0, UNTYPED},
        '{ROW_TICK,  1'b1, 1'b0, CFG_PERIOD_TOP,     16'd0,     1'b0, UNTYPED},
        '{ROW_TICK,  1'b1, 1'b1, CFG_PERIOD_TOP,     16'd0,     1'b0, UNTYPED},
        '{ROW_TICK,  1'b1, 1'b1, CFG_PERIOD_TOP,     16'd0,     1'b0, UNTYPED},
        '{ROW_TICK,  1'b1, 1'b0, CFG_PERIOD_TOP,     16'd0,     1'b0, UNTYPED},
        '{ROW_TICK,  1'b1, 1'b1, CFG_PERIOD_TOP,     16'd0,     1'b0, UNTYPED},
        '{ROW_TICK,  1'b1, 1'b0, CFG_PERIOD_TOP,     16'd0,     1'b0, UNTYPED},
        '{ROW_TICK,  1'b1, 1'b1, CFG_PERIOD_TOP,     16'd0,     1'b0, UNTYPED},
        '{ROW_TICK,  1'b1, 1'b1, CFG_PERIOD_TOP,     16'd0,     1'b0, UNTYPED},
        '{ROW_TICK,  1'b1, 1'b1, CFG_PERIOD_TOP,     16'd0,     1'b0, UNTYPED},
        '{ROW_WRITE, 1'b1, 1'b1, CFG_PERIOD_TOP,     16'd65535, 1'b0, UNTYPED},
        '{ROW_WRITE, 1'b1, 1'b1, CFG_DEBOUNCE_TICKS, 16'd65535, 1'b0, UNTYPED},
        '{ROW_TICK,  1'b1, 1'b1, CFG_PERIOD_TOP,     16'd0,     1'b0, UNTYPED},
        '{ROW_WRITE, 1'b1, 1'b1, CFG_DEBOUNCE_TICKS, 16'd1,     1'b0, UNTYPED},
        '{ROW_TICK,  1'b0, 1'b1, CFG_PERIOD_TOP,     16'd0,     1'b0, UNTYPED},
        '{ROW_TICK,  1'b0, 1'b1, CFG_PERIOD_TOP,     16'd0,     1'b0, UNTYPED},
        '{ROW_TICK,  1'b1, 1'b1, CFG_PERIOD_TOP,     16'd0,     1'b0, UNTYPED}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic pressure_on;

    bspwm_in_if  item_if ();
    bspwm_out_if result_if ();
    bspwm_cfg_if cfg_if ();

    button_stepped_pwm #(
        .COUNT_WIDTH (COUNT_W),
        .DUTY_STEP   (STEP)
    ) DUT (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_cfg    (cfg_if),
        .i_item   (item_if),
        .o_result (result_if)
    );

    always #5 clk = ~clk;

    // shadow copy of the block state
    logic [CFG_W-1:0]   top_val;
    logic [CFG_W-1:0]   debounce_val;
    logic [COUNT_W-1:0] tick_cnt;
    logic [COUNT_W-1:0] cmp_active;
    logic [COUNT_W-1:0] cmp_pending;
    logic [DUTY_W-1:0]  duty_now;
    bit                 btn_prev [2];
    logic [CFG_W-1:0]   btn_wait [2];
    int                 hold_left [2];

    t_pwm_result expected_q [$];

    int error_count    = 0;
    int ticks_sent     = 0;
    int results_seen   = 0;
    int wraps_seen     = 0;
    bit max_duty_seen  = 1'b0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int stall_left     = 0;
    bit stall_taken    = 1'b0;

    function automatic void reset_shadow();
        top_val      = RESET_PERIOD_TOP;
        debounce_val = RESET_DEBOUNCE;
        tick_cnt     = '0;
        cmp_active   = COUNT_W'(RESET_COMPARE);
        cmp_pending  = COUNT_W'(RESET_COMPARE);
        duty_now     = RESET_DUTY;
        btn_prev     = '{1'b1, 1'b1};
        btn_wait     = '{'0, '0};
        hold_left    = '{0, 0};
    endfunction

    function automatic void load_duty(int d);
        duty_now    = DUTY_W'(d);
        cmp_pending = COUNT_W'((64'(top_val) * d) / int'(DUTY_MAX));
    endfunction

    function automatic bit press_confirmed(int b, bit lvl);
        bit fire;
        fire = 1'b0;
        if (btn_wait[b] != 0) begin
            btn_wait[b] = btn_wait[b] - 1'b1;
            fire = (btn_wait[b] == 0) && !lvl;
        end else if (btn_prev[b] && !lvl) begin
            if (debounce_val == 0) begin
                fire = 1'b1;
            end else begin
                btn_wait[b] = debounce_val;
            end
        end
        btn_prev[b] = lvl;
        return fire;
    endfunction

    function automatic t_pwm_result predict_tick(bit up, bit dn);
        t_pwm_result r;
        bit          up_fire;
        bit          dn_fire;
        r.pwm = (tick_cnt <= cmp_active);
        if (tick_cnt >= top_val) begin
            r.wrap     = 1'b1;
            tick_cnt   = '0;
            cmp_active = cmp_pending;
        end else begin
            r.wrap   = 1'b0;
            tick_cnt = tick_cnt + 1'b1;
        end
        up_fire = press_confirmed(BTN_UP, up);
        dn_fire = press_confirmed(BTN_DN, dn);
        if (up_fire && duty_now < DUTY_MAX) begin
            load_duty((int'(duty_now) + STEP > int'(DUTY_MAX)) ? int'(DUTY_MAX)
                                                                : int'(duty_now) + STEP);
        end
        if (dn_fire && duty_now > DUTY_MIN) begin
            load_duty((int'(duty_now) >= int'(DUTY_MIN) + STEP) ? int'(duty_now) - STEP
                                                                 : int'(DUTY_MIN));
        end
        r.duty = duty_now;
        return r;
    endfunction

    // mostly held presses around the debounce length, with bounce and short blips
    function automatic bit next_level(int b);
        int span;
        span = (debounce_val > 8) ? 8 : int'(debounce_val);
        if (hold_left[b] > 0) begin
            hold_left[b]--;
            return ($urandom_range(0, 19) == 0);
        end
        if ($urandom_range(0, 3) == 0) begin
            hold_left[b] = $urandom_range(1, span + 3);
            return 1'b0;
        end
        return ($urandom_range(0, 9) != 0);
    endfunction

    task automatic report_mismatch(string msg);
        error_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic send_tick(bit up, bit dn, bit typed, t_pwm_result want);
        t_pwm_result model_out;
        cfg_if.valid <= 1'b0;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            item_if.valid <= 1'b0;
            @(posedge clk);
        end
        item_if.valid      <= 1'b1;
        item_if.up_level   <= up;
        item_if.down_level <= dn;
        do @(posedge clk); while (!item_if.ready);
        model_out = predict_tick(up, dn);
        expected_q.push_back(typed ? want : model_out);
        ticks_sent++;
    endtask

    task automatic wait_results_drained();
        item_if.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [CFG_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge clk); while (!cfg_if.ready);
        if (idx == CFG_PERIOD_TOP) begin
            top_val = val;
        end else begin
            debounce_val = val;
        end
    endtask

    task automatic run_random_set(logic [CFG_W-1:0] top, logic [CFG_W-1:0] deb);
        wait_results_drained();
        write_reg(CFG_PERIOD_TOP, top);
        write_reg(CFG_DEBOUNCE_TICKS, deb);
        hold_left = '{0, 0};
        repeat (TICKS_PER_SET) begin
            send_tick(next_level(BTN_UP), next_level(BTN_DN), 1'b0, UNTYPED);
        end
    endtask

    // result checker and receiver throttle
    always @(posedge clk) begin : result_check
        t_pwm_result got;
        t_pwm_result want;
        if (!rst_n) begin
            result_if.ready <= 1'b0;
            stall_left      <= 0;
            stall_taken     <= 1'b0;
        end else begin
            if (result_if.valid && result_if.ready) begin
                got.pwm  = result_if.pwm_level;
                got.duty = result_if.duty_percent;
                got.wrap = result_if.period_wrap;
                if (got.wrap) wraps_seen++;
                if (got.duty == DUTY_MAX) max_duty_seen = 1'b1;
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              results_seen));
                end else begin
                    want = expected_q.pop_front();
                    if (got.pwm !== want.pwm)
                        report_mismatch($sformatf("result %0d pwm_level got %0b want %0b",
                                                  results_seen, got.pwm, want.pwm));
                    if (got.duty !== want.duty)
                        report_mismatch($sformatf("result %0d duty_percent got %0d want %0d",
                                                  results_seen, got.duty, want.duty));
                    if (got.wrap !== want.wrap)
                        report_mismatch($sformatf("result %0d period_wrap got %0b want %0b",
                                                  results_seen, got.wrap, want.wrap));
                end
                results_seen++;
            end
            if (pressure_on && !stall_taken) begin
                stall_taken     <= 1'b1;
                stall_left      <= STALL_CYCLES;
                result_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left      <= stall_left - 1;
                result_if.ready <= 1'b0;
            end else begin
                result_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d results still expected", expected_q.size());
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        rst_n              <= 1'b0;
        pressure_on        <= 1'b0;
        item_if.valid      <= 1'b0;
        item_if.up_level   <= 1'b1;
        item_if.down_level <= 1'b1;
        cfg_if.valid       <= 1'b0;
        cfg_if.index       <= CFG_PERIOD_TOP;
        cfg_if.data        <= '0;
        reset_shadow();
        send_idle_pct = 38;
        recv_idle_pct = 68;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_WRITE) begin
                if (i == 0 || directed_rows[i-1].kind == ROW_TICK) wait_results_drained();
                write_reg(directed_rows[i].idx, directed_rows[i].data);
            end else begin
                send_tick(directed_rows[i].up, directed_rows[i].dn,
                          directed_rows[i].typed, directed_rows[i].want);
            end
        end

        // sender idles less than receiver
        run_random_set(16'd7, 16'd2);
        run_random_set(16'd1, 16'd0);
        run_random_set(16'd20, 16'd5);

        // receiver idles less than sender; the wide top leaves the count above the next top
        send_idle_pct = 68;
        recv_idle_pct = 38;
        run_random_set(16'd3, 16'd1);
        run_random_set(16'd65535, 16'd3);
        run_random_set(16'd4, 16'd4);

        // back to back, opening with a long output stall
        send_idle_pct = 0;
        recv_idle_pct = 0;
        wait_results_drained();
        pressure_on <= 1'b1;
        run_random_set(16'd12, 16'd2);
        run_random_set(16'd2, 16'd0);
        run_random_set(CFG_W'($urandom_range(1, 40)), CFG_W'($urandom_range(0, 6)));

        wait_results_drained();
        $display("covered %0d ticks (directed table and nine random register sets), %0d results",
                 ticks_sent, results_seen);
        $display("saw %0d period wraps, duty at its ceiling %s, one %0d cycle output stall",
                 wraps_seen, max_duty_seen ? "reached" : "not reached", STALL_CYCLES);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/bspwm_pkg.sv
rtl/bspwm_if.sv
rtl/bspwm_debounce.sv
rtl/bspwm_div100.sv
rtl/button_stepped_pwm.sv
rtl/bspwm_checker.sv
tb/button_stepped_pwm_tb.sv
